// ===== hdl/ipa_pkg.sv =====
// Shared types, operation codes and status codes of the ID pool allocator.
`default_nettype none

package ipa_pkg;

    // Payload field types.
    typedef logic [1:0]        func_t;
    typedef logic signed [10:0] free_id_t;
    typedef logic [9:0]        granted_id_t;
    typedef logic [1:0]        status_t;

    // Operation codes.
    localparam func_t FUNC_ALLOC    = 2'd0;
    localparam func_t FUNC_FREE     = 2'd1;
    localparam func_t FUNC_FREE_ALL = 2'd2;

    // Status codes.
    localparam status_t ST_OK            = 2'd0;
    localparam status_t ST_NOT_ALLOCATED = 2'd1;
    localparam status_t ST_NEGATIVE      = 2'd2;
    localparam status_t ST_EXHAUSTED     = 2'd3;

    // Width of the ID as it appears on the ports.
    localparam int PORT_ID_W = 10;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic commit;
    } ipa_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/ipa_if.sv =====
// Request and response channel interfaces of the ID pool allocator.
`default_nettype none

interface ipa_req_if import ipa_pkg::*; ();
    logic     valid;
    logic     ready;
    func_t    func;
    free_id_t free_id;

    modport source (output valid, output func, output free_id, input ready);
    modport sink (input valid, input func, input free_id, output ready);
endinterface

interface ipa_rsp_if import ipa_pkg::*; ();
    logic        valid;
    logic        ready;
    granted_id_t granted_id;
    status_t     status;

    modport source (output valid, output granted_id, output status, input ready);
    modport sink (input valid, input granted_id, input status, output ready);
endinterface

`default_nettype wire

// ===== hdl/ipa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module ipa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/ipa_ctrl.sv =====
// Controller: sequences each transaction through a read step and a commit step.
`default_nettype none

module ipa_ctrl import ipa_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output ipa_cmd_t  cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;

    // A new request is taken only when no transaction is in flight.
    assign req_ready   = (state_reg == ST_IDLE);
    assign cmd.capture = req_valid && req_ready;
    // Commit once the output register is free or is being emptied.
    assign cmd.commit  = (state_reg == ST_EXEC) && (!out_valid_reg || rsp_ready);
    assign rsp_valid   = out_valid_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (cmd.commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register occupancy.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ipa_dp.sv =====
// Datapath: free stack, allocation marks, counters and the result register.
`default_nettype none

module ipa_dp import ipa_pkg::*; #(
    parameter int MAX_IDS = 1024
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire ipa_cmd_t cmd,
    input  wire func_t    in_func,
    input  wire free_id_t in_free_id,
    output granted_id_t   granted_id,
    output status_t       status
);

    localparam int ID_W  = $clog2(MAX_IDS);
    localparam int CNT_W = $clog2(MAX_IDS + 1);
    localparam int XW    = (ID_W > PORT_ID_W) ? ID_W : PORT_ID_W;
    localparam int CMP_W = (CNT_W > PORT_ID_W) ? CNT_W : PORT_ID_W;

    logic [CNT_W-1:0] depth_reg;
    logic [CNT_W-1:0] depth_next;
    logic [CNT_W-1:0] fresh_reg;
    logic [CNT_W-1:0] fresh_next;
    func_t            func_reg;
    free_id_t         id_reg;
    granted_id_t      granted_reg;
    granted_id_t      granted_next;
    status_t          status_reg;
    status_t          status_next;

    logic [ID_W-1:0]  mark_raddr;
    logic             mark_rdata;
    logic             mark_we;
    logic [ID_W-1:0]  mark_waddr;
    logic             mark_wdata;
    logic [ID_W-1:0]  stack_raddr;
    logic [ID_W-1:0]  stack_rdata;
    logic             stack_we;
    logic [ID_W-1:0]  stack_waddr;

    logic [XW-1:0]    in_id_x;
    logic [XW-1:0]    reg_id_x;
    logic [XW-1:0]    grant_x;
    logic [CNT_W-1:0] depth_m1;
    logic [ID_W-1:0]  grant_id;
    logic             id_marked;

    // Widen the port IDs to the internal width before cutting to the address.
    assign in_id_x  = XW'(in_free_id[PORT_ID_W-1:0]);
    assign reg_id_x = XW'(id_reg[PORT_ID_W-1:0]);
    assign depth_m1 = depth_reg - 1'b1;

    // Mark read address: the request while it is taken, the held copy afterwards.
    assign mark_raddr  = cmd.capture ? in_id_x[ID_W-1:0] : reg_id_x[ID_W-1:0];
    assign stack_raddr = depth_m1[ID_W-1:0];

    // Every ID below the fresh counter was written since the last clear,
    // so a mark at or above it reads as cleared.
    assign id_marked = (CMP_W'(id_reg[PORT_ID_W-1:0]) < CMP_W'(fresh_reg)) && mark_rdata;

    assign stack_waddr = depth_reg[ID_W-1:0];

    // Decide the result and the state updates of the held transaction.
    always_comb
    begin
        depth_next   = depth_reg;
        fresh_next   = fresh_reg;
        granted_next = '0;
        status_next  = ST_OK;
        mark_we      = 1'b0;
        mark_waddr   = reg_id_x[ID_W-1:0];
        mark_wdata   = 1'b0;
        stack_we     = 1'b0;
        grant_id     = '0;
        grant_x      = '0;
        case (func_reg)
            FUNC_ALLOC:
            begin
                if (depth_reg != '0)
                begin
                    grant_id   = stack_rdata;
                    depth_next = depth_m1;
                    mark_we    = 1'b1;
                end
                else if (fresh_reg != CNT_W'(MAX_IDS))
                begin
                    grant_id   = fresh_reg[ID_W-1:0];
                    fresh_next = fresh_reg + 1'b1;
                    mark_we    = 1'b1;
                end
                else
                begin
                    status_next = ST_EXHAUSTED;
                end
                grant_x      = XW'(grant_id);
                granted_next = grant_x[PORT_ID_W-1:0];
                mark_waddr   = grant_id;
                mark_wdata   = 1'b1;
            end
            FUNC_FREE:
            begin
                if (id_reg[PORT_ID_W])
                begin
                    status_next = ST_NEGATIVE;
                end
                else if (!id_marked)
                begin
                    status_next = ST_NOT_ALLOCATED;
                end
                else
                begin
                    mark_we = 1'b1;
                    if (depth_reg != CNT_W'(MAX_IDS))
                    begin
                        stack_we   = 1'b1;
                        depth_next = depth_reg + 1'b1;
                    end
                end
            end
            FUNC_FREE_ALL:
            begin
                depth_next = '0;
                fresh_next = '0;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // Allocation marks, one bit per ID.
    ipa_ram #(
        .WIDTH (1),
        .DEPTH (MAX_IDS)
    ) u_mark_ram (
        .clk   (clk),
        .we    (mark_we && cmd.commit),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .raddr (mark_raddr),
        .rdata (mark_rdata)
    );

    // Last-in-first-out stack of freed IDs.
    ipa_ram #(
        .WIDTH (ID_W),
        .DEPTH (MAX_IDS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stack_we && cmd.commit),
        .waddr (stack_waddr),
        .wdata (reg_id_x[ID_W-1:0]),
        .raddr (stack_raddr),
        .rdata (stack_rdata)
    );

    // Request holding registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= in_func;
            id_reg   <= in_free_id;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            granted_reg <= granted_next;
            status_reg  <= status_next;
        end
    end

    // Stack depth and fresh counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
            fresh_reg <= '0;
        end
        else if (cmd.commit)
        begin
            depth_reg <= depth_next;
            fresh_reg <= fresh_next;
        end
    end

    assign granted_id = granted_reg;
    assign status     = status_reg;

endmodule

`default_nettype wire

// ===== hdl/id_pool_allocator.sv =====
// A taken request is held in the request registers, then committed into the output
// register from the exec state, waiting only while the previous result is stalled.
// Each transaction runs a registered read of the mark and stack RAMs and then the
// read-modify-write commit; no new request is taken until that commit is done.
// A new request is taken while the previous result still waits in the output register.
// Reset clears the stack depth, the fresh counter and the handshake state at once;
// no clearing pass runs, marks at or above the fresh counter read as cleared.
`default_nettype none

module id_pool_allocator import ipa_pkg::*; #(
    parameter int MAX_IDS = 1024
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ipa_req_if.sink   req,
    ipa_rsp_if.source rsp
);

    ipa_cmd_t cmd;

    // Transaction sequencing.
    ipa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    // Pool storage and result computation.
    ipa_dp #(
        .MAX_IDS (MAX_IDS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_func    (req.func),
        .in_free_id (req.free_id),
        .granted_id (rsp.granted_id),
        .status     (rsp.status)
    );

endmodule

`default_nettype wire

// ===== hdl/ipa_chk.sv =====
// Port-level checker of the ID pool allocator and its binding to the top level.
`default_nettype none

module ipa_chk import ipa_pkg::*; (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire granted_id_t rsp_granted_id,
    input wire status_t     rsp_status
);

    // Only one transaction is in flight: ready drops right after a request is taken.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while a transaction was in flight");

    // A result appearing in an empty output register comes from its request with no wait.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("result appeared without a request two cycles earlier");

    // Only a successful allocate hands out an ID.
    a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ST_OK) |-> (rsp_granted_id == '0))
        else $error("nonzero ID granted with a failing status");

    // A stalled result holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=>
            rsp_valid && $stable(rsp_granted_id) && $stable(rsp_status))
        else $error("stalled result changed");

endmodule

bind id_pool_allocator ipa_chk u_ipa_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_granted_id (rsp.granted_id),
    .rsp_status     (rsp.status)
);

`default_nettype wire
